// ----- sv/pqts_pkg.sv -----
// Package for the piecewise quintic trajectory sampler.
// Types, codes, constants and fixed-point helpers; no dependencies.
package pqts_pkg;

  localparam int DefMaxPieces = 16;
  localparam int NumAxes      = 3;
  localparam int NumTerms     = 6;
  localparam int W48          = 48;

  localparam logic [1:0] REQ_COEF   = 2'd0;
  localparam logic [1:0] REQ_DUR    = 2'd1;
  localparam logic [1:0] REQ_SAMPLE = 2'd2;

  localparam logic [1:0] ST_SAMPLED = 2'd0;
  localparam logic [1:0] ST_BEFORE  = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_LOAD    = 2'd3;

  localparam logic signed [47:0] S48Max = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] S48Min = 48'sh8000_0000_0000;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         piece_sel;
    logic [1:0]         axis_sel;
    logic [2:0]         term_sel;
    logic signed [47:0] load_value;
    logic signed [31:0] sample_time;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         piece_index;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [47:0] pos_z;
    logic signed [47:0] vel_x;
    logic signed [47:0] vel_y;
    logic signed [47:0] vel_z;
    logic signed [47:0] acc_x;
    logic signed [47:0] acc_y;
    logic signed [47:0] acc_z;
  } resp_t;

  typedef logic signed [47:0] s48_t;
  typedef s48_t coef_row_t [NumAxes][NumTerms];

  // Saturate a wide signed value to 48 bits.
  function automatic s48_t sat48(input logic signed [63:0] v);
    if (v > 64'(S48Max)) return S48Max;
    if (v < 64'(S48Min)) return S48Min;
    return v[47:0];
  endfunction

  // Scale a coefficient by a small constant and saturate.
  function automatic s48_t scale_sat(input s48_t c, input logic [4:0] f);
    logic signed [63:0] p;
    p = 64'(c) * $signed({59'd0, f});
    return sat48(p);
  endfunction

endpackage

// ----- sv/pqts_horner_step.sv -----
// One registered Horner step for nine lanes: acc*tau/2^16 rounded, plus coefficient.
// Uses pqts_pkg. The 48x31 product is cut into partial products of the low 32 and high 16 magnitude bits.
module pqts_horner_step
  import pqts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [30:0] tau,
  input  s48_t        acc     [9],
  input  s48_t        coef    [9],
  input  logic        use_lane[9],
  output logic        out_valid,
  output s48_t        result  [9]
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  for (genvar g = 0; g < 9; g++) begin : g_lane
    logic        neg;
    logic [47:0] mag;
    logic [63:0] lo;
    logic [47:0] hi;
    logic [63:0] r;
    logic [48:0] rc;
    logic signed [63:0] sum;
    always_comb begin
      neg = acc[g][47];
      mag = neg ? 48'(-acc[g]) : acc[g];
      lo  = 64'(mag[31:0]) * 64'(tau) + 64'h8000;
      hi  = 48'(mag[47:32]) * 48'(tau);
      r   = ({16'd0, hi} << 16) + (lo >> 16);
      rc  = (r > 64'h1_0000_0000_0000) ? 49'h1_0000_0000_0000 : r[48:0];
      sum = (neg ? -$signed({15'd0, rc}) : $signed({15'd0, rc})) + 64'(coef[g]);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        result[g] <= use_lane[g] ? sat48(sum) : acc[g];
      end
    end
  end

endmodule

// ----- sv/piecewise_quintic_trajectory_sampler.sv -----
// Top level of the piecewise quintic trajectory sampler: tables, piece search, Horner pipe.
// Uses pqts_pkg and pqts_horner_step.
//
// A request passes a fixed pipeline: piece lookup, local time and coefficient row read, then
// derivative scaling, five Horner stages and an output register, nine lanes side by side.
// One request enters every cycle while the output is not stalled. A result is valid once it
// has passed every register of that pipeline. A stall at the output holds
// the whole pipe. Loads write the tables at transfer and pass down the pipe so results keep
// order. Reset clears the durations and their running ends. Coefficients hold through reset
// and must be loaded before a sample reads them.
module piecewise_quintic_trajectory_sampler
  import pqts_pkg::*;
#(
  parameter int MAX_PIECES = DefMaxPieces
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  req_t       in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output resp_t      out_data
);

  localparam int PW = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
  localparam int CW = $clog2(MAX_PIECES + 1);

  logic [CW-1:0] piece_count;
  s48_t          coef_mem [MAX_PIECES][NumAxes][NumTerms];
  logic [30:0]   dur_mem  [MAX_PIECES];
  logic [38:0]   ends     [MAX_PIECES];

  logic en;
  logic in_fire;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      piece_count <= '0;
    end else if (cfg_we) begin
      piece_count <= (32'(cfg_data) > MAX_PIECES) ? CW'(MAX_PIECES) : CW'(cfg_data);
    end
  end

  // Coefficient table writes at transfer.
  always_ff @(posedge clk) begin
    if (in_fire && 32'(in_data.piece_sel) < MAX_PIECES) begin
      if (in_data.req_type == REQ_COEF && in_data.axis_sel < 2'd3 &&
          in_data.term_sel < 3'd6) begin
        coef_mem[PW'(in_data.piece_sel)][in_data.axis_sel][in_data.term_sel] <=
          in_data.load_value;
      end
    end
  end

  // Keep a running end per piece: a duration load adds its change to every end from its
  // piece onwards.
  logic [30:0] dur_new;
  logic [38:0] dur_delta;
  assign dur_new   = in_data.load_value[47] ? 31'd0 :
                     (|in_data.load_value[46:31]) ? 31'h7FFF_FFFF : in_data.load_value[30:0];
  assign dur_delta = 39'(dur_new) - 39'(dur_mem[PW'(in_data.piece_sel)]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PIECES; i++) begin
        dur_mem[i] <= '0;
        ends[i]    <= '0;
      end
    end else if (in_fire && in_data.req_type == REQ_DUR &&
                 32'(in_data.piece_sel) < MAX_PIECES) begin
      dur_mem[PW'(in_data.piece_sel)] <= dur_new;
      for (int i = 0; i < MAX_PIECES; i++) begin
        if (i >= 32'(in_data.piece_sel)) ends[i] <= ends[i] + dur_delta;
      end
    end
  end

  // Stage 1: piece search over cumulative ends.
  logic           any_zero;
  logic [PW-1:0]  idx;
  logic           found;
  logic [38:0]    start1;
  always_comb begin
    any_zero = 1'b0;
    for (int i = 0; i < MAX_PIECES; i++) begin
      if (i < 32'(piece_count) && dur_mem[i] == 31'd0) any_zero = 1'b1;
    end
    idx   = PW'(piece_count - CW'(1));
    found = 1'b0;
    for (int i = 0; i < MAX_PIECES; i++) begin
      if (!found && i < 32'(piece_count) &&
          $signed({8'd0, in_data.sample_time}) <= $signed({1'b0, ends[i]})) begin
        idx = PW'(i);
        found = 1'b1;
      end
    end
    start1 = (idx == '0) ? 39'd0 : ends[idx - PW'(1)];
  end

  logic signed [40:0] loc;
  logic [30:0]        tau1;
  always_comb begin
    loc  = 41'(in_data.sample_time) - $signed({2'd0, start1});
    tau1 = (loc < 0) ? 31'd0 :
           (loc > $signed({10'd0, dur_mem[idx]})) ? dur_mem[idx] : loc[30:0];
  end

  logic          s1_valid;
  logic [1:0]    s1_status;
  logic [PW-1:0] s1_idx;
  logic [30:0]   s1_tau;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_fire;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_idx <= '0;
      s1_tau <= tau1;
      if (in_data.req_type == REQ_COEF || in_data.req_type == REQ_DUR) begin
        s1_status <= ST_LOAD;
      end else if (in_data.req_type != REQ_SAMPLE || piece_count == '0 || any_zero) begin
        s1_status <= ST_INVALID;
      end else if (in_data.sample_time[31]) begin
        s1_status <= ST_BEFORE;
      end else begin
        s1_status <= ST_SAMPLED;
        s1_idx    <= idx;
      end
    end
  end

  // Read the coefficient row alongside stage 1; a time before start reads piece 0.
  s48_t c2 [NumAxes][NumTerms];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < NumAxes; a++)
        for (int k = 0; k < NumTerms; k++)
          c2[a][k] <= coef_mem[in_data.sample_time[31] ? PW'(0) : idx][a][k];
    end
  end

  // Stage 2: scale derivative coefficients, seed lanes.
  localparam int NS = 5;
  s48_t        lane_acc [NS+1][9];
  s48_t        lane_cf  [NS+1][9];
  logic        lane_v   [NS+1];
  logic [1:0]  st_p     [NS+1];
  logic [3:0]  ix_p     [NS+1];
  logic [30:0] tau_p    [NS+1];
  s48_t        kcoef    [NS][9];
  s48_t        acc0     [9];
  logic        v0;

  assign lane_acc[0] = acc0;
  assign lane_v[0]   = v0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s1_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      st_p[0]  <= s1_status;
      ix_p[0]  <= 4'(s1_idx);
      tau_p[0] <= s1_tau;
      for (int a = 0; a < NumAxes; a++) begin
        acc0[a]   <= c2[a][5];
        acc0[3+a] <= scale_sat(c2[a][5], 5'd5);
        acc0[6+a] <= scale_sat(c2[a][5], 5'd20);
        for (int j = 0; j < NS; j++) begin
          kcoef[j][a]   <= c2[a][4-j];
          kcoef[j][3+a] <= (j < 4) ? scale_sat(c2[a][4-j], 5'(4-j)) : '0;
          kcoef[j][6+a] <= (j == 0) ? scale_sat(c2[a][4], 5'd12) :
                           (j == 1) ? scale_sat(c2[a][3], 5'd6) :
                           (j == 2) ? scale_sat(c2[a][2], 5'd2) : '0;
        end
        // Before start: position and velocity come straight from piece 0.
        lane_cf[0][a] <= c2[a][0];
        lane_cf[0][3+a] <= c2[a][1];
        lane_cf[0][6+a] <= '0;
      end
      for (int s = 1; s <= NS; s++) lane_cf[s] <= lane_cf[s-1];
      for (int s = 0; s < NS; s++) begin
        st_p[s+1]  <= st_p[s];
        ix_p[s+1]  <= ix_p[s];
        tau_p[s+1] <= tau_p[s];
      end
    end
  end

  // Coefficient delay lines keep each later step's operands aligned.
  s48_t kd [NS][NS][9];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NS; j++) begin
        kd[j][0] <= kcoef[j];
        for (int d = 1; d < NS; d++) kd[j][d] <= kd[j][d-1];
      end
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_step
    s48_t cf [9];
    logic use_l [9];
    always_comb begin
      for (int l = 0; l < 9; l++) begin
        cf[l]    = (s == 0) ? kcoef[s][l] : kd[s][(s == 0) ? 0 : s-1][l];
        use_l[l] = (l < 3) || (l < 6 && s < 4) || (s < 3);
      end
    end
    pqts_horner_step u_step (
      .clk(clk), .rst(rst), .en(en), .in_valid(lane_v[s]), .tau(tau_p[s]),
      .acc(lane_acc[s]), .coef(cf), .use_lane(use_l),
      .out_valid(lane_v[s+1]), .result(lane_acc[s+1])
    );
  end

  // Output register.
  s48_t fin [9];
  always_comb begin
    for (int l = 0; l < 9; l++) begin
      case (st_p[NS])
        ST_SAMPLED: fin[l] = lane_acc[NS][l];
        ST_BEFORE:  fin[l] = (l < 6) ? lane_cf[NS][l] : '0;
        default:    fin[l] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= lane_v[NS];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.status      <= st_p[NS];
      out_data.piece_index <= (st_p[NS] == ST_SAMPLED) ? ix_p[NS] : 4'd0;
      out_data.pos_x <= fin[0];
      out_data.pos_y <= fin[1];
      out_data.pos_z <= fin[2];
      out_data.vel_x <= fin[3];
      out_data.vel_y <= fin[4];
      out_data.vel_z <= fin[5];
      out_data.acc_x <= fin[6];
      out_data.acc_y <= fin[7];
      out_data.acc_z <= fin[8];
    end
  end

endmodule
